// File: sv/twc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_pkg: shared types and constants of the two-way cache tag lookup
// Field widths of the request and result ports, parameter defaults and the
// layout of one directory row (both tags and the most-recently-used bit).
// ----------------------------------------------------------------------------
package twc_pkg;

  // Port field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned OFFSET_W = 5;
  localparam int unsigned BLOCK_W  = 27;
  localparam int unsigned SET_W    = 6;
  localparam int unsigned TAG_W    = 21;
  localparam int unsigned COUNT_W  = 32;

  // Parameter defaults
  localparam int unsigned SET_COUNT_DEF    = 64;
  localparam int unsigned LINE_BYTES_DEF   = 32;
  localparam int unsigned ADDRESS_BITS_DEF = 32;

  // One directory row: most recently used way and the tag of each way
  typedef struct packed {
    logic             recent;
    logic [TAG_W-1:0] tag1;
    logic [TAG_W-1:0] tag0;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

endpackage : twc_pkg

// File: sv/two_way_cache_tag_lookup_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_cache_tag_lookup_lru: two-way set-associative tag directory, LRU
// Splits each request address into offset, block, set and tag, looks the tag
// up in both ways, fills or evicts, and reports the outcome with running hit
// and reference counts.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the result side does not stall. The
// accept edge registers the address in the lookup stage and reads the
// directory row of its set from the tag RAM; when the lookup retires, the
// result register is loaded while the updated row is written back. A
// row written at the same edge at which the following request
// reads it is forwarded from a bypass register, so back-to-back requests to
// one set see each other. Valid bits sit in flip-flops and clear at reset at
// once; there is no clearing pass, and the tag RAM itself is not reset.
// SET_COUNT and LINE_BYTES must be powers of two. A stall on the result side
// holds the lookup stage and, through it, the request side.
module two_way_cache_tag_lookup_lru #(
  parameter int unsigned SET_COUNT    = twc_pkg::SET_COUNT_DEF,
  parameter int unsigned LINE_BYTES   = twc_pkg::LINE_BYTES_DEF,
  parameter int unsigned ADDRESS_BITS = twc_pkg::ADDRESS_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [twc_pkg::ADDR_W-1:0]   address_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [twc_pkg::OFFSET_W-1:0] byte_offset_o,
  output logic [twc_pkg::BLOCK_W-1:0]  block_number_o,
  output logic [twc_pkg::SET_W-1:0]    set_index_o,
  output logic                         way_used_o,
  output logic [twc_pkg::TAG_W-1:0]    line_tag_o,
  output logic                         is_miss_o,
  output logic                         is_replacement_o,
  output logic [twc_pkg::TAG_W-1:0]    evicted_tag_o,
  output logic [twc_pkg::COUNT_W-1:0]  hit_total_o,
  output logic [twc_pkg::COUNT_W-1:0]  reference_total_o
);

  localparam int unsigned OFF_BITS = $clog2(LINE_BYTES);
  localparam int unsigned SET_BITS = $clog2(SET_COUNT);
  localparam logic [63:0] ADDR_MASK64 =
    (ADDRESS_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDRESS_BITS) - 64'd1);
  localparam logic [twc_pkg::ADDR_W-1:0] ADDR_MASK = ADDR_MASK64[twc_pkg::ADDR_W-1:0];
  localparam logic [twc_pkg::ADDR_W-1:0] OFF_MASK  = twc_pkg::ADDR_W'(LINE_BYTES - 1);
  localparam logic [twc_pkg::ADDR_W-1:0] SET_MASK  = twc_pkg::ADDR_W'(SET_COUNT - 1);

  // Handshake
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Request side set index, for the RAM read
  logic [twc_pkg::ADDR_W-1:0] in_addr;
  logic [twc_pkg::ADDR_W-1:0] in_block;
  logic [SET_BITS-1:0]        in_set;

  assign in_addr  = address_i & ADDR_MASK;
  assign in_block = in_addr >> OFF_BITS;
  assign in_set   = in_block[SET_BITS-1:0];

  // Lookup stage registers
  logic [twc_pkg::ADDR_W-1:0] addr_q;
  twc_pkg::row_t              rd_q;
  logic                       fwd_q;
  logic [SET_BITS-1:0]        last_set_q;
  twc_pkg::row_t              last_row_q;

  // Directory: tag RAM plus valid flops
  logic [twc_pkg::ROW_W-1:0] tag_mem [SET_COUNT];
  logic [SET_COUNT-1:0]      valid0_q;
  logic [SET_COUNT-1:0]      valid1_q;

  // Counters
  logic [twc_pkg::COUNT_W-1:0] hit_cnt_q;
  logic [twc_pkg::COUNT_W-1:0] ref_cnt_q;

  // Lookup stage decode
  logic [twc_pkg::ADDR_W-1:0] s1_block;
  logic [twc_pkg::ADDR_W-1:0] s1_set_full;
  logic [twc_pkg::ADDR_W-1:0] s1_tag_full;
  logic [twc_pkg::ADDR_W-1:0] s1_off_full;
  logic [SET_BITS-1:0]        s1_set;
  logic [twc_pkg::TAG_W-1:0]  s1_tag;

  assign s1_block    = addr_q >> OFF_BITS;
  assign s1_set_full = s1_block & SET_MASK;
  assign s1_tag_full = s1_block >> SET_BITS;
  assign s1_off_full = addr_q & OFF_MASK;
  assign s1_set      = s1_set_full[SET_BITS-1:0];
  assign s1_tag      = s1_tag_full[twc_pkg::TAG_W-1:0];

  // Pick the row: bypass when the previous write hit this set at our read edge
  twc_pkg::row_t row;
  logic          v0;
  logic          v1;

  assign row = (fwd_q && (last_set_q == s1_set)) ? last_row_q : rd_q;
  assign v0  = valid0_q[s1_set];
  assign v1  = valid1_q[s1_set];

  // Hit, fill or evict
  logic                      way;
  logic                      miss;
  logic                      repl;
  logic [twc_pkg::TAG_W-1:0] evicted;
  twc_pkg::row_t             new_row;

  always_comb begin
    way     = 1'b0;
    miss    = 1'b1;
    repl    = 1'b0;
    evicted = '0;
    new_row = row;
    if (!v0) begin
      new_row.tag0 = s1_tag;
    end else if (row.tag0 == s1_tag) begin
      miss = 1'b0;
    end else if (!v1) begin
      way          = 1'b1;
      new_row.tag1 = s1_tag;
    end else if (row.tag1 == s1_tag) begin
      way  = 1'b1;
      miss = 1'b0;
    end else if (row.recent) begin
      repl         = 1'b1;
      evicted      = row.tag0;
      new_row.tag0 = s1_tag;
    end else begin
      way          = 1'b1;
      repl         = 1'b1;
      evicted      = row.tag1;
      new_row.tag1 = s1_tag;
    end
    new_row.recent = way;
  end

  // Next counter values, including this request
  logic [twc_pkg::COUNT_W-1:0] hit_cnt_d;
  logic [twc_pkg::COUNT_W-1:0] ref_cnt_d;

  assign ref_cnt_d = ref_cnt_q + twc_pkg::COUNT_W'(1);
  assign hit_cnt_d = hit_cnt_q + twc_pkg::COUNT_W'(!miss);

  // Read the row on accept, write the updated row when the lookup retires
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= twc_pkg::row_t'(tag_mem[in_set]);
    end
    if (s1_fire) begin
      tag_mem[s1_set] <= new_row;
    end
  end

  // Lookup stage payload and bypass row
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      addr_q <= in_addr;
    end
    if (s1_fire) begin
      last_set_q <= s1_set;
      last_row_q <= new_row;
    end
  end

  // Control, valid bits and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
      valid0_q    <= '0;
      valid1_q    <= '0;
      hit_cnt_q   <= '0;
      ref_cnt_q   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_fire;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        hit_cnt_q   <= hit_cnt_d;
        ref_cnt_q   <= ref_cnt_d;
        if (way) begin
          valid1_q[s1_set] <= 1'b1;
        end else begin
          valid0_q[s1_set] <= 1'b1;
        end
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      byte_offset_o     <= s1_off_full[twc_pkg::OFFSET_W-1:0];
      block_number_o    <= s1_block[twc_pkg::BLOCK_W-1:0];
      set_index_o       <= s1_set_full[twc_pkg::SET_W-1:0];
      way_used_o        <= way;
      line_tag_o        <= s1_tag;
      is_miss_o         <= miss;
      is_replacement_o  <= repl;
      evicted_tag_o     <= evicted;
      hit_total_o       <= hit_cnt_d;
      reference_total_o <= ref_cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // An empty lookup stage never stalls the request side
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("request side stalled with an empty lookup stage");

  // Every retired lookup advances the reference count by one
  a_ref_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> ref_cnt_q == $past(ref_cnt_q) + twc_pkg::COUNT_W'(1))
    else $error("reference count did not advance");

  // The way used by a retired lookup is valid afterwards
  a_way_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> ($past(way) ? valid1_q[$past(s1_set)] : valid0_q[$past(s1_set)]))
    else $error("used way left invalid");

  // A hit neither evicts nor reports an evicted tag
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !is_miss_o |-> !is_replacement_o && (evicted_tag_o == '0))
    else $error("hit reported an eviction");

  // Way 1 is never valid in a set whose way 0 is invalid
  a_fill_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && v1 |-> v0)
    else $error("way 1 valid without way 0");

endmodule : two_way_cache_tag_lookup_lru

// File: sim/tag_lookup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_lookup_checker: request/result checker for the two-way tag directory
// Keeps its own copy of the directory (valid bits, tags, most-recently-used
// way, hit and reference counts), works out the result of every accepted
// request and compares each accepted result with the oldest one waiting.
// ----------------------------------------------------------------------------
module tag_lookup_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [twc_pkg::ADDR_W-1:0]   address_i,
  // Result channel
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [twc_pkg::OFFSET_W-1:0] byte_offset_i,
  input  logic [twc_pkg::BLOCK_W-1:0]  block_number_i,
  input  logic [twc_pkg::SET_W-1:0]    set_index_i,
  input  logic                         way_used_i,
  input  logic [twc_pkg::TAG_W-1:0]    line_tag_i,
  input  logic                         is_miss_i,
  input  logic                         is_replacement_i,
  input  logic [twc_pkg::TAG_W-1:0]    evicted_tag_i,
  input  logic [twc_pkg::COUNT_W-1:0]  hit_total_i,
  input  logic [twc_pkg::COUNT_W-1:0]  reference_total_i,
  // Status towards the testbench top
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  localparam int unsigned SETS       = twc_pkg::SET_COUNT_DEF;
  localparam int unsigned LINE_SHIFT = $clog2(twc_pkg::LINE_BYTES_DEF);
  localparam int unsigned CMP_W      = twc_pkg::COUNT_W;

  typedef struct packed {
    logic [twc_pkg::OFFSET_W-1:0] byte_offset;
    logic [twc_pkg::BLOCK_W-1:0]  block_number;
    logic [twc_pkg::SET_W-1:0]    set_index;
    logic                         way_used;
    logic [twc_pkg::TAG_W-1:0]    line_tag;
    logic                         is_miss;
    logic                         is_replacement;
    logic [twc_pkg::TAG_W-1:0]    evicted_tag;
    logic [twc_pkg::COUNT_W-1:0]  hit_total;
    logic [twc_pkg::COUNT_W-1:0]  reference_total;
  } lookup_result_t;

  // Shadow directory
  logic                        dir_valid0 [SETS];
  logic                        dir_valid1 [SETS];
  logic [twc_pkg::TAG_W-1:0]   dir_tag0   [SETS];
  logic [twc_pkg::TAG_W-1:0]   dir_tag1   [SETS];
  logic                        dir_recent [SETS];
  logic [twc_pkg::COUNT_W-1:0] hits_seen;
  logic [twc_pkg::COUNT_W-1:0] refs_seen;

  lookup_result_t pending_lookups [$];
  lookup_result_t oldest;
  int unsigned    mismatches = 0;
  int unsigned    queued     = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = queued;

  // Look one address up in the shadow directory and update it
  function automatic lookup_result_t lookup_directory(
    input logic [twc_pkg::ADDR_W-1:0] addr
  );
    lookup_result_t r;
    logic [twc_pkg::BLOCK_W-1:0] block;
    logic [twc_pkg::TAG_W-1:0]   tag;
    int unsigned                 row;
    block            = twc_pkg::BLOCK_W'(addr >> LINE_SHIFT);
    row              = block % SETS;
    tag              = twc_pkg::TAG_W'(block / SETS);
    r.byte_offset    = addr[twc_pkg::OFFSET_W-1:0];
    r.block_number   = block;
    r.set_index      = twc_pkg::SET_W'(row);
    r.line_tag       = tag;
    r.is_miss        = 1'b1;
    r.is_replacement = 1'b0;
    r.evicted_tag    = '0;
    refs_seen        = refs_seen + twc_pkg::COUNT_W'(1);
    if (!dir_valid0[row]) begin
      dir_valid0[row] = 1'b1;
      dir_tag0[row]   = tag;
      r.way_used      = 1'b0;
    end else if (dir_tag0[row] == tag) begin
      r.is_miss  = 1'b0;
      r.way_used = 1'b0;
    end else if (!dir_valid1[row]) begin
      dir_valid1[row] = 1'b1;
      dir_tag1[row]   = tag;
      r.way_used      = 1'b1;
    end else if (dir_tag1[row] == tag) begin
      r.is_miss  = 1'b0;
      r.way_used = 1'b1;
    end else if (dir_recent[row]) begin
      // Way 1 was used last: evict way 0
      r.is_replacement = 1'b1;
      r.evicted_tag    = dir_tag0[row];
      dir_tag0[row]    = tag;
      r.way_used       = 1'b0;
    end else begin
      r.is_replacement = 1'b1;
      r.evicted_tag    = dir_tag1[row];
      dir_tag1[row]    = tag;
      r.way_used       = 1'b1;
    end
    dir_recent[row] = r.way_used;
    if (!r.is_miss) begin
      hits_seen = hits_seen + twc_pkg::COUNT_W'(1);
    end
    r.hit_total       = hits_seen;
    r.reference_total = refs_seen;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [CMP_W-1:0] want,
                               input logic [CMP_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Match results against the oldest prediction, then predict new requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SETS; i++) begin
        dir_valid0[i] = 1'b0;
        dir_valid1[i] = 1'b0;
        dir_tag0[i]   = '0;
        dir_tag1[i]   = '0;
        dir_recent[i] = 1'b0;
      end
      hits_seen = '0;
      refs_seen = '0;
      pending_lookups.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_lookups.size() == 0) begin
          $error("result with no request outstanding (block_number 0x%0h)", block_number_i);
          mismatches++;
        end else begin
          oldest = pending_lookups.pop_front();
          compare_field("byte_offset", CMP_W'(oldest.byte_offset),
                        CMP_W'(byte_offset_i));
          compare_field("block_number", CMP_W'(oldest.block_number),
                        CMP_W'(block_number_i));
          compare_field("set_index", CMP_W'(oldest.set_index), CMP_W'(set_index_i));
          compare_field("way_used", CMP_W'(oldest.way_used), CMP_W'(way_used_i));
          compare_field("line_tag", CMP_W'(oldest.line_tag), CMP_W'(line_tag_i));
          compare_field("is_miss", CMP_W'(oldest.is_miss), CMP_W'(is_miss_i));
          compare_field("is_replacement", CMP_W'(oldest.is_replacement),
                        CMP_W'(is_replacement_i));
          compare_field("evicted_tag", CMP_W'(oldest.evicted_tag),
                        CMP_W'(evicted_tag_i));
          compare_field("hit_total", oldest.hit_total, hit_total_i);
          compare_field("reference_total", oldest.reference_total, reference_total_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_lookups.push_back(lookup_directory(address_i));
      end
    end
    queued = pending_lookups.size();
  end

endmodule : tag_lookup_checker

// File: sim/two_way_cache_tag_lookup_lru_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_cache_tag_lookup_lru_tb: testbench top for the two-way tag lookup
// Drives a directed run through fills, hits and evictions on both ways, then
// random requests concentrated on a few sets and tags so that hits and LRU
// evictions are frequent, with random request gaps and result-side stalls. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module two_way_cache_tag_lookup_lru_tb;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RAND_BLOCKS  = 10;
  localparam int unsigned BLOCK_ITEMS  = 104;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_stall_o;
  logic [twc_pkg::ADDR_W-1:0]   address_i    = '0;
  logic                         out_valid_o;
  logic                         out_stall_i  = 1'b0;
  logic [twc_pkg::OFFSET_W-1:0] byte_offset_o;
  logic [twc_pkg::BLOCK_W-1:0]  block_number_o;
  logic [twc_pkg::SET_W-1:0]    set_index_o;
  logic                         way_used_o;
  logic [twc_pkg::TAG_W-1:0]    line_tag_o;
  logic                         is_miss_o;
  logic                         is_replacement_o;
  logic [twc_pkg::TAG_W-1:0]    evicted_tag_o;
  logic [twc_pkg::COUNT_W-1:0]  hit_total_o;
  logic [twc_pkg::COUNT_W-1:0]  reference_total_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  int unsigned stall_run   = 0;
  bit          calm        = 1'b1;

  logic [twc_pkg::SET_W-1:0]  hot_rows [4];
  logic [twc_pkg::TAG_W-1:0]  hot_tags [5];
  logic [twc_pkg::ADDR_W-1:0] last_addr = '0;

  always #5 clk_i = ~clk_i;

  two_way_cache_tag_lookup_lru u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .address_i         (address_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .byte_offset_o     (byte_offset_o),
    .block_number_o    (block_number_o),
    .set_index_o       (set_index_o),
    .way_used_o        (way_used_o),
    .line_tag_o        (line_tag_o),
    .is_miss_o         (is_miss_o),
    .is_replacement_o  (is_replacement_o),
    .evicted_tag_o     (evicted_tag_o),
    .hit_total_o       (hit_total_o),
    .reference_total_o (reference_total_o)
  );

  tag_lookup_checker u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .address_i         (address_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .byte_offset_i     (byte_offset_o),
    .block_number_i    (block_number_o),
    .set_index_i       (set_index_o),
    .way_used_i        (way_used_o),
    .line_tag_i        (line_tag_o),
    .is_miss_i         (is_miss_o),
    .is_replacement_i  (is_replacement_o),
    .evicted_tag_i     (evicted_tag_o),
    .hit_total_i       (hit_total_o),
    .reference_total_i (reference_total_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [twc_pkg::ADDR_W-1:0] pack_address(
    input logic [twc_pkg::TAG_W-1:0]    tag,
    input logic [twc_pkg::SET_W-1:0]    row,
    input logic [twc_pkg::OFFSET_W-1:0] off
  );
    return {tag, row, off};
  endfunction

  // Present one request, hold it until taken, then maybe idle
  task automatic send_request(input logic [twc_pkg::ADDR_W-1:0] addr);
    logic taken;
    in_valid_i <= 1'b1;
    address_i  <= addr;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
  endtask

  // Hold off the request side until every outstanding result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (pending != 0);
    @(posedge clk_i);
  endtask

  // Random stalls on the result side
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      stall_run   = stall_run - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_run   = gap_len() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned                pick;
    logic [twc_pkg::ADDR_W-1:0] addr;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, fills of both ways, hits on both, LRU evictions
    send_request('0);
    send_request('1);
    send_request(pack_address(21'h000000, 6'd0, 5'd31));
    send_request(pack_address(21'h000005, 6'd0, 5'd0));
    send_request(pack_address(21'h000005, 6'd0, 5'd7));
    // Evict way 0 holding tag zero: replacement with a zero evicted tag
    send_request(pack_address(21'h000009, 6'd0, 5'd0));
    send_request(pack_address(21'h000005, 6'd0, 5'd0));
    send_request(pack_address(21'h1FFFFF, 6'd0, 5'd16));
    send_request(pack_address(21'h000003, 6'd0, 5'd1));
    send_request(pack_address(21'h000000, 6'd63, 5'd0));
    send_request(pack_address(21'h1FFFFF, 6'd63, 5'd31));
    send_request(pack_address(21'h0AAAAA, 6'd63, 5'h15));
    send_request(pack_address(21'h155555, 6'd63, 5'h0A));
    send_request(pack_address(21'h155555, 6'd21, 5'd0));
    send_request(pack_address(21'h0AAAAA, 6'd42, 5'd31));
    drain_results();

    // Random: mostly a few hot sets and tags, some same-line repeats, some noise
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 4; i++) begin
        hot_rows[i] = twc_pkg::SET_W'($urandom_range(0, 63));
      end
      for (int i = 0; i < 5; i++) begin
        hot_tags[i] = twc_pkg::TAG_W'($urandom());
      end
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          addr = pack_address(hot_tags[$urandom_range(0, 4)], hot_rows[$urandom_range(0, 3)],
                              twc_pkg::OFFSET_W'($urandom()));
        end else if (pick < 85) begin
          addr = last_addr ^ twc_pkg::ADDR_W'($urandom_range(0, 31));
        end else begin
          addr = $urandom();
        end
        send_request(addr);
        last_addr = addr;
      end
      if ($urandom_range(0, 2) == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : two_way_cache_tag_lookup_lru_tb
